FILE: sv/aes256_pkg.sv
// shared types, constants and byte functions for the aes-256 decryptor
package aes256_pkg;

    localparam int KEY_REGS = 4;
    localparam int ROUND_KEY_WORDS = 60;
    localparam logic [1:0] KEY_IDX_0 = 2'd0;
    localparam logic [1:0] KEY_IDX_1 = 2'd1;
    localparam logic [1:0] KEY_IDX_2 = 2'd2;
    localparam logic [1:0] KEY_IDX_3 = 2'd3;
    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] REDUCE_POLY = 8'h1B;

    typedef logic [127:0] block_t;
    typedef logic [31:0] word_t;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] v);
        logic [7:0] r;
        case (v)
            8'h00: r = 8'h63; 8'h01: r = 8'h7C; 8'h02: r = 8'h77; 8'h03: r = 8'h7B;
            8'h04: r = 8'hF2; 8'h05: r = 8'h6B; 8'h06: r = 8'h6F; 8'h07: r = 8'hC5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0A: r = 8'h67; 8'h0B: r = 8'h2B;
            8'h0C: r = 8'hFE; 8'h0D: r = 8'hD7; 8'h0E: r = 8'hAB; 8'h0F: r = 8'h76;
            8'h10: r = 8'hCA; 8'h11: r = 8'h82; 8'h12: r = 8'hC9; 8'h13: r = 8'h7D;
            8'h14: r = 8'hFA; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hF0;
            8'h18: r = 8'hAD; 8'h19: r = 8'hD4; 8'h1A: r = 8'hA2; 8'h1B: r = 8'hAF;
            8'h1C: r = 8'h9C; 8'h1D: r = 8'hA4; 8'h1E: r = 8'h72; 8'h1F: r = 8'hC0;
            8'h20: r = 8'hB7; 8'h21: r = 8'hFD; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3F; 8'h26: r = 8'hF7; 8'h27: r = 8'hCC;
            8'h28: r = 8'h34; 8'h29: r = 8'hA5; 8'h2A: r = 8'hE5; 8'h2B: r = 8'hF1;
            8'h2C: r = 8'h71; 8'h2D: r = 8'hD8; 8'h2E: r = 8'h31; 8'h2F: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hC7; 8'h32: r = 8'h23; 8'h33: r = 8'hC3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9A;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3A: r = 8'h80; 8'h3B: r = 8'hE2;
            8'h3C: r = 8'hEB; 8'h3D: r = 8'h27; 8'h3E: r = 8'hB2; 8'h3F: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2C; 8'h43: r = 8'h1A;
            8'h44: r = 8'h1B; 8'h45: r = 8'h6E; 8'h46: r = 8'h5A; 8'h47: r = 8'hA0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3B; 8'h4A: r = 8'hD6; 8'h4B: r = 8'hB3;
            8'h4C: r = 8'h29; 8'h4D: r = 8'hE3; 8'h4E: r = 8'h2F; 8'h4F: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hD1; 8'h52: r = 8'h00; 8'h53: r = 8'hED;
            8'h54: r = 8'h20; 8'h55: r = 8'hFC; 8'h56: r = 8'hB1; 8'h57: r = 8'h5B;
            8'h58: r = 8'h6A; 8'h59: r = 8'hCB; 8'h5A: r = 8'hBE; 8'h5B: r = 8'h39;
            8'h5C: r = 8'h4A; 8'h5D: r = 8'h4C; 8'h5E: r = 8'h58; 8'h5F: r = 8'hCF;
            8'h60: r = 8'hD0; 8'h61: r = 8'hEF; 8'h62: r = 8'hAA; 8'h63: r = 8'hFB;
            8'h64: r = 8'h43; 8'h65: r = 8'h4D; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hF9; 8'h6A: r = 8'h02; 8'h6B: r = 8'h7F;
            8'h6C: r = 8'h50; 8'h6D: r = 8'h3C; 8'h6E: r = 8'h9F; 8'h6F: r = 8'hA8;
            8'h70: r = 8'h51; 8'h71: r = 8'hA3; 8'h72: r = 8'h40; 8'h73: r = 8'h8F;
            8'h74: r = 8'h92; 8'h75: r = 8'h9D; 8'h76: r = 8'h38; 8'h77: r = 8'hF5;
            8'h78: r = 8'hBC; 8'h79: r = 8'hB6; 8'h7A: r = 8'hDA; 8'h7B: r = 8'h21;
            8'h7C: r = 8'h10; 8'h7D: r = 8'hFF; 8'h7E: r = 8'hF3; 8'h7F: r = 8'hD2;
            8'h80: r = 8'hCD; 8'h81: r = 8'h0C; 8'h82: r = 8'h13; 8'h83: r = 8'hEC;
            8'h84: r = 8'h5F; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hC4; 8'h89: r = 8'hA7; 8'h8A: r = 8'h7E; 8'h8B: r = 8'h3D;
            8'h8C: r = 8'h64; 8'h8D: r = 8'h5D; 8'h8E: r = 8'h19; 8'h8F: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4F; 8'h93: r = 8'hDC;
            8'h94: r = 8'h22; 8'h95: r = 8'h2A; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hEE; 8'h9A: r = 8'hB8; 8'h9B: r = 8'h14;
            8'h9C: r = 8'hDE; 8'h9D: r = 8'h5E; 8'h9E: r = 8'h0B; 8'h9F: r = 8'hDB;
            8'hA0: r = 8'hE0; 8'hA1: r = 8'h32; 8'hA2: r = 8'h3A; 8'hA3: r = 8'h0A;
            8'hA4: r = 8'h49; 8'hA5: r = 8'h06; 8'hA6: r = 8'h24; 8'hA7: r = 8'h5C;
            8'hA8: r = 8'hC2; 8'hA9: r = 8'hD3; 8'hAA: r = 8'hAC; 8'hAB: r = 8'h62;
            8'hAC: r = 8'h91; 8'hAD: r = 8'h95; 8'hAE: r = 8'hE4; 8'hAF: r = 8'h79;
            8'hB0: r = 8'hE7; 8'hB1: r = 8'hC8; 8'hB2: r = 8'h37; 8'hB3: r = 8'h6D;
            8'hB4: r = 8'h8D; 8'hB5: r = 8'hD5; 8'hB6: r = 8'h4E; 8'hB7: r = 8'hA9;
            8'hB8: r = 8'h6C; 8'hB9: r = 8'h56; 8'hBA: r = 8'hF4; 8'hBB: r = 8'hEA;
            8'hBC: r = 8'h65; 8'hBD: r = 8'h7A; 8'hBE: r = 8'hAE; 8'hBF: r = 8'h08;
            8'hC0: r = 8'hBA; 8'hC1: r = 8'h78; 8'hC2: r = 8'h25; 8'hC3: r = 8'h2E;
            8'hC4: r = 8'h1C; 8'hC5: r = 8'hA6; 8'hC6: r = 8'hB4; 8'hC7: r = 8'hC6;
            8'hC8: r = 8'hE8; 8'hC9: r = 8'hDD; 8'hCA: r = 8'h74; 8'hCB: r = 8'h1F;
            8'hCC: r = 8'h4B; 8'hCD: r = 8'hBD; 8'hCE: r = 8'h8B; 8'hCF: r = 8'h8A;
            8'hD0: r = 8'h70; 8'hD1: r = 8'h3E; 8'hD2: r = 8'hB5; 8'hD3: r = 8'h66;
            8'hD4: r = 8'h48; 8'hD5: r = 8'h03; 8'hD6: r = 8'hF6; 8'hD7: r = 8'h0E;
            8'hD8: r = 8'h61; 8'hD9: r = 8'h35; 8'hDA: r = 8'h57; 8'hDB: r = 8'hB9;
            8'hDC: r = 8'h86; 8'hDD: r = 8'hC1; 8'hDE: r = 8'h1D; 8'hDF: r = 8'h9E;
            8'hE0: r = 8'hE1; 8'hE1: r = 8'hF8; 8'hE2: r = 8'h98; 8'hE3: r = 8'h11;
            8'hE4: r = 8'h69; 8'hE5: r = 8'hD9; 8'hE6: r = 8'h8E; 8'hE7: r = 8'h94;
            8'hE8: r = 8'h9B; 8'hE9: r = 8'h1E; 8'hEA: r = 8'h87; 8'hEB: r = 8'hE9;
            8'hEC: r = 8'hCE; 8'hED: r = 8'h55; 8'hEE: r = 8'h28; 8'hEF: r = 8'hDF;
            8'hF0: r = 8'h8C; 8'hF1: r = 8'hA1; 8'hF2: r = 8'h89; 8'hF3: r = 8'h0D;
            8'hF4: r = 8'hBF; 8'hF5: r = 8'hE6; 8'hF6: r = 8'h42; 8'hF7: r = 8'h68;
            8'hF8: r = 8'h41; 8'hF9: r = 8'h99; 8'hFA: r = 8'h2D; 8'hFB: r = 8'h0F;
            8'hFC: r = 8'hB0; 8'hFD: r = 8'h54; 8'hFE: r = 8'hBB; 8'hFF: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        case (v)
            8'h00: r = 8'h52; 8'h01: r = 8'h09; 8'h02: r = 8'h6A; 8'h03: r = 8'hD5;
            8'h04: r = 8'h30; 8'h05: r = 8'h36; 8'h06: r = 8'hA5; 8'h07: r = 8'h38;
            8'h08: r = 8'hBF; 8'h09: r = 8'h40; 8'h0A: r = 8'hA3; 8'h0B: r = 8'h9E;
            8'h0C: r = 8'h81; 8'h0D: r = 8'hF3; 8'h0E: r = 8'hD7; 8'h0F: r = 8'hFB;
            8'h10: r = 8'h7C; 8'h11: r = 8'hE3; 8'h12: r = 8'h39; 8'h13: r = 8'h82;
            8'h14: r = 8'h9B; 8'h15: r = 8'h2F; 8'h16: r = 8'hFF; 8'h17: r = 8'h87;
            8'h18: r = 8'h34; 8'h19: r = 8'h8E; 8'h1A: r = 8'h43; 8'h1B: r = 8'h44;
            8'h1C: r = 8'hC4; 8'h1D: r = 8'hDE; 8'h1E: r = 8'hE9; 8'h1F: r = 8'hCB;
            8'h20: r = 8'h54; 8'h21: r = 8'h7B; 8'h22: r = 8'h94; 8'h23: r = 8'h32;
            8'h24: r = 8'hA6; 8'h25: r = 8'hC2; 8'h26: r = 8'h23; 8'h27: r = 8'h3D;
            8'h28: r = 8'hEE; 8'h29: r = 8'h4C; 8'h2A: r = 8'h95; 8'h2B: r = 8'h0B;
            8'h2C: r = 8'h42; 8'h2D: r = 8'hFA; 8'h2E: r = 8'hC3; 8'h2F: r = 8'h4E;
            8'h30: r = 8'h08; 8'h31: r = 8'h2E; 8'h32: r = 8'hA1; 8'h33: r = 8'h66;
            8'h34: r = 8'h28; 8'h35: r = 8'hD9; 8'h36: r = 8'h24; 8'h37: r = 8'hB2;
            8'h38: r = 8'h76; 8'h39: r = 8'h5B; 8'h3A: r = 8'hA2; 8'h3B: r = 8'h49;
            8'h3C: r = 8'h6D; 8'h3D: r = 8'h8B; 8'h3E: r = 8'hD1; 8'h3F: r = 8'h25;
            8'h40: r = 8'h72; 8'h41: r = 8'hF8; 8'h42: r = 8'hF6; 8'h43: r = 8'h64;
            8'h44: r = 8'h86; 8'h45: r = 8'h68; 8'h46: r = 8'h98; 8'h47: r = 8'h16;
            8'h48: r = 8'hD4; 8'h49: r = 8'hA4; 8'h4A: r = 8'h5C; 8'h4B: r = 8'hCC;
            8'h4C: r = 8'h5D; 8'h4D: r = 8'h65; 8'h4E: r = 8'hB6; 8'h4F: r = 8'h92;
            8'h50: r = 8'h6C; 8'h51: r = 8'h70; 8'h52: r = 8'h48; 8'h53: r = 8'h50;
            8'h54: r = 8'hFD; 8'h55: r = 8'hED; 8'h56: r = 8'hB9; 8'h57: r = 8'hDA;
            8'h58: r = 8'h5E; 8'h59: r = 8'h15; 8'h5A: r = 8'h46; 8'h5B: r = 8'h57;
            8'h5C: r = 8'hA7; 8'h5D: r = 8'h8D; 8'h5E: r = 8'h9D; 8'h5F: r = 8'h84;
            8'h60: r = 8'h90; 8'h61: r = 8'hD8; 8'h62: r = 8'hAB; 8'h63: r = 8'h00;
            8'h64: r = 8'h8C; 8'h65: r = 8'hBC; 8'h66: r = 8'hD3; 8'h67: r = 8'h0A;
            8'h68: r = 8'hF7; 8'h69: r = 8'hE4; 8'h6A: r = 8'h58; 8'h6B: r = 8'h05;
            8'h6C: r = 8'hB8; 8'h6D: r = 8'hB3; 8'h6E: r = 8'h45; 8'h6F: r = 8'h06;
            8'h70: r = 8'hD0; 8'h71: r = 8'h2C; 8'h72: r = 8'h1E; 8'h73: r = 8'h8F;
            8'h74: r = 8'hCA; 8'h75: r = 8'h3F; 8'h76: r = 8'h0F; 8'h77: r = 8'h02;
            8'h78: r = 8'hC1; 8'h79: r = 8'hAF; 8'h7A: r = 8'hBD; 8'h7B: r = 8'h03;
            8'h7C: r = 8'h01; 8'h7D: r = 8'h13; 8'h7E: r = 8'h8A; 8'h7F: r = 8'h6B;
            8'h80: r = 8'h3A; 8'h81: r = 8'h91; 8'h82: r = 8'h11; 8'h83: r = 8'h41;
            8'h84: r = 8'h4F; 8'h85: r = 8'h67; 8'h86: r = 8'hDC; 8'h87: r = 8'hEA;
            8'h88: r = 8'h97; 8'h89: r = 8'hF2; 8'h8A: r = 8'hCF; 8'h8B: r = 8'hCE;
            8'h8C: r = 8'hF0; 8'h8D: r = 8'hB4; 8'h8E: r = 8'hE6; 8'h8F: r = 8'h73;
            8'h90: r = 8'h96; 8'h91: r = 8'hAC; 8'h92: r = 8'h74; 8'h93: r = 8'h22;
            8'h94: r = 8'hE7; 8'h95: r = 8'hAD; 8'h96: r = 8'h35; 8'h97: r = 8'h85;
            8'h98: r = 8'hE2; 8'h99: r = 8'hF9; 8'h9A: r = 8'h37; 8'h9B: r = 8'hE8;
            8'h9C: r = 8'h1C; 8'h9D: r = 8'h75; 8'h9E: r = 8'hDF; 8'h9F: r = 8'h6E;
            8'hA0: r = 8'h47; 8'hA1: r = 8'hF1; 8'hA2: r = 8'h1A; 8'hA3: r = 8'h71;
            8'hA4: r = 8'h1D; 8'hA5: r = 8'h29; 8'hA6: r = 8'hC5; 8'hA7: r = 8'h89;
            8'hA8: r = 8'h6F; 8'hA9: r = 8'hB7; 8'hAA: r = 8'h62; 8'hAB: r = 8'h0E;
            8'hAC: r = 8'hAA; 8'hAD: r = 8'h18; 8'hAE: r = 8'hBE; 8'hAF: r = 8'h1B;
            8'hB0: r = 8'hFC; 8'hB1: r = 8'h56; 8'hB2: r = 8'h3E; 8'hB3: r = 8'h4B;
            8'hB4: r = 8'hC6; 8'hB5: r = 8'hD2; 8'hB6: r = 8'h79; 8'hB7: r = 8'h20;
            8'hB8: r = 8'h9A; 8'hB9: r = 8'hDB; 8'hBA: r = 8'hC0; 8'hBB: r = 8'hFE;
            8'hBC: r = 8'h78; 8'hBD: r = 8'hCD; 8'hBE: r = 8'h5A; 8'hBF: r = 8'hF4;
            8'hC0: r = 8'h1F; 8'hC1: r = 8'hDD; 8'hC2: r = 8'hA8; 8'hC3: r = 8'h33;
            8'hC4: r = 8'h88; 8'hC5: r = 8'h07; 8'hC6: r = 8'hC7; 8'hC7: r = 8'h31;
            8'hC8: r = 8'hB1; 8'hC9: r = 8'h12; 8'hCA: r = 8'h10; 8'hCB: r = 8'h59;
            8'hCC: r = 8'h27; 8'hCD: r = 8'h80; 8'hCE: r = 8'hEC; 8'hCF: r = 8'h5F;
            8'hD0: r = 8'h60; 8'hD1: r = 8'h51; 8'hD2: r = 8'h7F; 8'hD3: r = 8'hA9;
            8'hD4: r = 8'h19; 8'hD5: r = 8'hB5; 8'hD6: r = 8'h4A; 8'hD7: r = 8'h0D;
            8'hD8: r = 8'h2D; 8'hD9: r = 8'hE5; 8'hDA: r = 8'h7A; 8'hDB: r = 8'h9F;
            8'hDC: r = 8'h93; 8'hDD: r = 8'hC9; 8'hDE: r = 8'h9C; 8'hDF: r = 8'hEF;
            8'hE0: r = 8'hA0; 8'hE1: r = 8'hE0; 8'hE2: r = 8'h3B; 8'hE3: r = 8'h4D;
            8'hE4: r = 8'hAE; 8'hE5: r = 8'h2A; 8'hE6: r = 8'hF5; 8'hE7: r = 8'hB0;
            8'hE8: r = 8'hC8; 8'hE9: r = 8'hEB; 8'hEA: r = 8'hBB; 8'hEB: r = 8'h3C;
            8'hEC: r = 8'h83; 8'hED: r = 8'h53; 8'hEE: r = 8'h99; 8'hEF: r = 8'h61;
            8'hF0: r = 8'h17; 8'hF1: r = 8'h2B; 8'hF2: r = 8'h04; 8'hF3: r = 8'h7E;
            8'hF4: r = 8'hBA; 8'hF5: r = 8'h77; 8'hF6: r = 8'hD6; 8'hF7: r = 8'h26;
            8'hF8: r = 8'hE1; 8'hF9: r = 8'h69; 8'hFA: r = 8'h14; 8'hFB: r = 8'h63;
            8'hFC: r = 8'h55; 8'hFD: r = 8'h21; 8'hFE: r = 8'h0C; 8'hFF: r = 8'h7D;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? REDUCE_POLY : 8'h00);
    endfunction

    // multiply by 0x09, 0x0b, 0x0d, 0x0e via doubling chain
    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int i = 0; i < 4; i++)
        begin
            a[i] = col[31 - 8 * i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

endpackage

FILE: sv/aes256_block_decrypt.sv
// aes-256 block decryptor top level with key expansion and round unit
//
// key: four 64-bit registers written over the cfg request channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is always high.
// key writes are expected only while no block is in flight.
// cipher request: in_valid/in_ready with cipher_high/cipher_low.
// plain request: out_valid/out_ready with plain_high/plain_low.
// round keys live in a 60-word ram with registered read.
// after a key write the first block triggers expansion: one word a cycle
// for all 60 words (8 key words, then 52 derived), each derived word needing
// the word 8 back (second read port avoided by keeping the last eight words
// in a window of registers).
// a block takes a read-priming step, four key reads a round over 15 key
// additions and a step to present the result; the next request is taken
// the cycle after the result is handed off, and the word ram port sets
// the pace of a block.
// a stalled receiver holds the result and blocks new requests upstream.
// reset clears control state and key registers and marks the key as not expanded.
module aes256_block_decrypt
    import aes256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] cipher_high,
    input  logic [63:0] cipher_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] plain_high,
    output logic [63:0] plain_low
);

    localparam int AW = $clog2(ROUND_KEY_WORDS);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXP  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [AW-1:0] LAST_WORD = AW'(ROUND_KEY_WORDS - 1);

    logic [2:0]      state_reg, state_next;
    logic [63:0]     key_reg [KEY_REGS];
    logic            key_ok_reg;
    logic [AW-1:0]   widx_reg;
    logic [7:0]      rcon_reg;
    word_t           win_reg [8];
    block_t          blk_reg;
    // round-key read address steps up within a round, down across rounds;
    // col_reg tracks the word lane
    logic [AW-1:0]   raddr_reg;
    logic            rvalid_reg;
    logic [1:0]      col_reg;
    logic [3:0]      round_reg;
    word_t           acc_reg [3];
    logic            out_valid_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    word_t           ram_wdata;
    word_t           ram_rdata;
    word_t           exp_word;
    word_t           t_word;
    block_t          shifted;
    block_t          rnd_result;
    word_t           key_words [8];

    assign cfg_ready = 1'b1;
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    aes256_ram #(.WIDTH(32), .DEPTH(ROUND_KEY_WORDS)) u_rk (
        .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
        .rd_addr(raddr_reg), .rd_data(ram_rdata)
    );

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            key_words[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
        end
    end

    // window holds words i-8 .. i-1, oldest at index 0
    always_comb
    begin
        t_word = win_reg[7];
        if (widx_reg[2:0] == 3'd0)
        begin
            t_word = sub_word({win_reg[7][23:0], win_reg[7][31:24]}) ^ {rcon_reg, 24'h0};
        end
        else if (widx_reg[2:0] == 3'd4)
        begin
            t_word = sub_word(win_reg[7]);
        end
        exp_word = win_reg[0] ^ t_word;
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = widx_reg;
        ram_wdata = exp_word;
        if (state_reg == ST_EXP)
        begin
            ram_we = 1'b1;
            ram_wdata = (widx_reg < AW'(8)) ? key_words[widx_reg[2:0]] : exp_word;
        end
    end

    // inv shift rows then inv sub bytes on the whole state
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                shifted[127 - 8 * (c * 4 + r) -: 8] =
                    inv_sbox(blk_reg[127 - 8 * ((((c - r) % 4 + 4) % 4) * 4 + r) -: 8]);
            end
        end
    end

    // round step once all four key words are in hand: key addition only for round 14, no inverse mix for round 0
    always_comb
    begin
        block_t ak;
        ak = {acc_reg[0], acc_reg[1], acc_reg[2], ram_rdata};
        if (round_reg == 4'd14)
        begin
            rnd_result = blk_reg ^ ak;
        end
        else if (round_reg == 4'd0)
        begin
            rnd_result = shifted ^ ak;
        end
        else
        begin
            ak = shifted ^ ak;
            rnd_result = {inv_mix_col(ak[127:96]), inv_mix_col(ak[95:64]),
                          inv_mix_col(ak[63:32]), inv_mix_col(ak[31:0])};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = key_ok_reg ? ST_RND : ST_EXP;
                end
            end
            ST_EXP:
            begin
                if (widx_reg == LAST_WORD)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                if (rvalid_reg && col_reg == 2'd3 && round_reg == 4'd0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rvalid_reg <= 1'b0;
            for (int i = 0; i < KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    KEY_IDX_0: key_reg[0] <= cfg_data;
                    KEY_IDX_1: key_reg[1] <= cfg_data;
                    KEY_IDX_2: key_reg[2] <= cfg_data;
                    KEY_IDX_3: key_reg[3] <= cfg_data;
                    default: key_reg[0] <= key_reg[0];
                endcase
                key_ok_reg <= 1'b0;
            end
            else if (state_reg == ST_EXP && widx_reg == LAST_WORD)
            begin
                key_ok_reg <= 1'b1;
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rvalid_reg <= (state_reg == ST_RND) && !(rvalid_reg && col_reg == 2'd3
                          && round_reg == 4'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_ready)
        begin
            blk_reg <= {cipher_high, cipher_low};
            widx_reg <= '0;
            rcon_reg <= RCON_INIT;
            raddr_reg <= AW'(ROUND_KEY_WORDS - 4);
            col_reg <= 2'd0;
            round_reg <= 4'd14;
        end
        if (state_reg == ST_EXP)
        begin
            widx_reg <= widx_reg + AW'(1);
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[7] <= ram_wdata;
            if (widx_reg >= AW'(8) && widx_reg[2:0] == 3'd0)
            begin
                rcon_reg <= xtime(rcon_reg);
            end
        end
        if (state_reg == ST_RND)
        begin
            // issue reads: four ascending words per round, rounds descending
            if (raddr_reg[1:0] == 2'd3)
            begin
                raddr_reg <= raddr_reg - AW'(7);
            end
            else
            begin
                raddr_reg <= raddr_reg + AW'(1);
            end
            if (rvalid_reg)
            begin
                col_reg <= col_reg + 2'd1;
                if (col_reg != 2'd3)
                begin
                    acc_reg[col_reg] <= ram_rdata;
                end
                else
                begin
                    blk_reg <= rnd_result;
                    round_reg <= round_reg - 4'd1;
                end
            end
        end
    end

    assign plain_high = blk_reg[127:64];
    assign plain_low = blk_reg[63:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("input taken while busy");
    a_key_before_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_RND) |-> key_ok_reg || (cfg_valid && cfg_ready))
        else $error("rounds started without expanded key");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> out_valid)
        else $error("result not presented");

endmodule

FILE: sv/aes256_ram.sv
// generic single-port-write ram with registered read
module aes256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: test/aes256_plain_scoreboard.sv
// request monitor with aes-256 inverse cipher predictor and plaintext compare
module aes256_plain_scoreboard
    import aes256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] cipher_high,
    input  logic [63:0] cipher_low,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] plain_high,
    input  logic [63:0] plain_low,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   sbox_fwd [256];
    logic [7:0]   sbox_inv [256];
    logic [63:0]  key_reg [KEY_REGS];
    word_t        sched [ROUND_KEY_WORDS];
    bit           sched_valid;
    block_t       plain_q [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    function automatic word_t sbox_word(input word_t w);
        return {sbox_fwd[w[31:24]], sbox_fwd[w[23:16]], sbox_fwd[w[15:8]], sbox_fwd[w[7:0]]};
    endfunction

    task automatic build_schedule();
        logic [7:0] rc;
        word_t      t;
        rc = 8'h01;
        for (int i = 0; i < 8; i++)
            sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = 8; i < ROUND_KEY_WORDS; i++)
        begin
            t = sched[i - 1];
            if (i % 8 == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            else if (i % 8 == 4)
                t = sbox_word(t);
            sched[i] = sched[i - 8] ^ t;
        end
        sched_valid = 1'b1;
    endtask

    function automatic block_t round_key(input int rnd);
        return {sched[4 * rnd], sched[4 * rnd + 1], sched[4 * rnd + 2], sched[4 * rnd + 3]};
    endfunction

    function automatic block_t unshift_unsub(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * c + r) -: 8] = sbox_inv[s[127 - 8 * (((c - r) & 3) * 4 + r) -: 8]];
        return t;
    endfunction

    function automatic block_t unmix(input block_t s);
        block_t     t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 32] = {
                gf_mul(a0, 8'h0E) ^ gf_mul(a1, 8'h0B) ^ gf_mul(a2, 8'h0D) ^ gf_mul(a3, 8'h09),
                gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0E) ^ gf_mul(a2, 8'h0B) ^ gf_mul(a3, 8'h0D),
                gf_mul(a0, 8'h0D) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0E) ^ gf_mul(a3, 8'h0B),
                gf_mul(a0, 8'h0B) ^ gf_mul(a1, 8'h0D) ^ gf_mul(a2, 8'h09) ^ gf_mul(a3, 8'h0E)};
        end
        return t;
    endfunction

    function automatic block_t decrypt_block(input block_t cipher);
        block_t s;
        s = cipher ^ round_key(14);
        for (int rnd = 13; rnd >= 1; rnd--)
            s = unmix(unshift_unsub(s) ^ round_key(rnd));
        return unshift_unsub(s) ^ round_key(0);
    endfunction

    // s-box from field inverse and affine map
    initial
    begin
        logic [7:0] inv, b;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            for (int x = 1; x < 256; x++)
                if (gf_mul(a[7:0], x[7:0]) == 8'h01)
                    inv = x[7:0];
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_fwd[a] = b;
            sbox_inv[b] = a[7:0];
        end
    end

    initial
    begin
        errors = 0;
        pending = 0;
        sched_valid = 1'b0;
        for (int i = 0; i < KEY_REGS; i++)
            key_reg[i] = 64'h0;
    end

    always @(posedge clk)
    begin
        block_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_reg[cfg_index] = cfg_data;
                sched_valid = 1'b0;
            end
            if (in_valid && in_ready)
            begin
                if (!sched_valid)
                    build_schedule();
                plain_q = {plain_q, decrypt_block({cipher_high, cipher_low})};
            end
            if (out_valid && out_ready)
            begin
                if (plain_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected plaintext %h_%h", $time, plain_high, plain_low);
                end
                else
                begin
                    want = plain_q.pop_front();
                    if (plain_high !== want[127:64])
                    begin
                        errors++;
                        $display("%0t: plain_high expected %h actual %h",
                                 $time, want[127:64], plain_high);
                    end
                    if (plain_low !== want[63:0])
                    begin
                        errors++;
                        $display("%0t: plain_low expected %h actual %h",
                                 $time, want[63:0], plain_low);
                    end
                end
            end
            pending = plain_q.size();
        end
    end

endmodule

FILE: test/tb_aes256_block_decrypt.sv
// testbench top: clock, reset, key and ciphertext stimulus, random stalls, verdict
module tb_aes256_block_decrypt;
    import aes256_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = KEY_IDX_0;
    logic [63:0] cfg_data = 64'h0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] cipher_high = 64'h0;
    logic [63:0] cipher_low = 64'h0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          no_gaps = 1'b0;

    always #6 clk = ~clk;

    aes256_block_decrypt dut (.*);

    aes256_plain_scoreboard scoreboard (.*);

    function automatic int gap_len();
        if (no_gaps)
            return 0;
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 60);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = 1'b1;
            if (!no_gaps)
            begin
                hold = gap_len();
                if (hold > 0)
                begin
                    out_ready = 1'b0;
                    repeat (hold) @(negedge clk);
                    out_ready = 1'b1;
                end
            end
        end
    end

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        repeat (gap_len()) @(negedge clk);
        in_valid = 1'b1;
        cipher_high = hi;
        cipher_low = lo;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [63:0] value);
        while (pending != 0)
            @(negedge clk);
        repeat (70) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_key(input logic [255:0] key);
        write_key(KEY_IDX_0, key[255:192]);
        write_key(KEY_IDX_1, key[191:128]);
        write_key(KEY_IDX_2, key[127:64]);
        write_key(KEY_IDX_3, key[63:0]);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_blocks(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0: send_block(64'h0, rand64());
                1: send_block(rand64(), 64'hFFFF_FFFF_FFFF_FFFF);
                default: send_block(rand64(), rand64());
            endcase
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key of all zeros
        send_block(64'h0, 64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);

        // standard test vector key
        load_key(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f);
        send_block(64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        send_block(64'h0, 64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);

        load_key({256{1'b1}});
        send_block(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

        // single register change forces a new expansion
        write_key(KEY_IDX_2, 64'h0);
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        write_key(KEY_IDX_0, 64'h5555_5555_5555_5555);
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

        no_gaps = 1'b1;
        load_key({rand64(), rand64(), rand64(), rand64()});
        for (int i = 0; i < 6; i++)
            send_block(rand64(), rand64());
        no_gaps = 1'b0;

        for (int phase = 0; phase < 19; phase++)
        begin
            if (phase % 4 == 3)
                write_key(2'($urandom_range(0, 3)), rand64());
            else
                load_key({rand64(), rand64(), rand64(), rand64()});
            no_gaps = (phase % 5 == 2);
            random_blocks(100);
        end
        no_gaps = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
